/* design/swm_pkg.sv */
`default_nettype none

package swm_pkg;

	// Default sizes for the top level parameters.
	localparam int WINDOW_MAX_DEF  = 64;
	localparam int SAMPLE_BITS_DEF = 32;

	// Width of the window size register.
	localparam int CFG_W = 7;

	// Operation broadcast to every cell of the sorted row.
	typedef struct packed {
		logic rmv;
		logic ins;
	} cell_ctl_t;

endpackage

`default_nettype wire

/* design/swm_if.sv */
`default_nettype none

// Sample channel: one beat carries a sample and its restart flag.
interface swm_in_if #(
	parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
) ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;
	logic                          restart;

	modport source (output valid, output sample, output restart, input ready);
	modport sink   (input valid, input sample, input restart, output ready);
endinterface

// Result channel: one beat carries the median of a full window.
interface swm_out_if #(
	parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
) ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] median;

	modport source (output valid, output median, input ready);
	modport sink   (input valid, input median, output ready);
endinterface

`default_nettype wire

/* design/swm_cell.sv */
`default_nettype none

module swm_cell #(
	parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF,
	parameter int CNT_W       = 7,
	parameter int IDX         = 0
) (
	input  wire logic                   clk,
	input  wire swm_pkg::cell_ctl_t     ctl,
	input  wire logic [CNT_W-1:0]       fill,
	input  wire logic [SAMPLE_BITS-1:0] x,
	input  wire logic [SAMPLE_BITS-1:0] d,
	input  wire logic [SAMPLE_BITS-1:0] left_key,
	input  wire logic                   left_after,
	input  wire logic [SAMPLE_BITS-1:0] right_key,
	output logic      [SAMPLE_BITS-1:0] key,
	output logic                        after
);
	import swm_pkg::*;

	localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);

	logic [SAMPLE_BITS-1:0] key_q;
	logic                   valid;
	logic                   shift_l;

	// A cell holds a live sample when its position is below the fill count.
	assign valid = IDX_C < fill;

	// Insertion point: this cell and all to its right move one place right.
	assign after = !valid || ($signed(key_q) > $signed(x));

	// Removal point: the first cell equal to the evicted sample and all to
	// its right take their right neighbor's key.
	assign shift_l = !valid || ($signed(key_q) >= $signed(d));

	// Whole-row shift, one operation per cycle.
	always_ff @(posedge clk) begin
		if (ctl.rmv) begin
			if (shift_l) begin
				key_q <= right_key;
			end
		end else if (ctl.ins) begin
			if (after) begin
				key_q <= left_after ? left_key : x;
			end
		end
	end

	assign key = key_q;

endmodule

`default_nettype wire

/* design/swm_ring.sv */
`default_nettype none

module swm_ring #(
	parameter int DEPTH       = swm_pkg::WINDOW_MAX_DEF,
	parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF,
	parameter int AW          = 6
) (
	input  wire logic                   clk,
	input  wire logic                   wr_en,
	input  wire logic [AW-1:0]          wr_addr,
	input  wire logic [SAMPLE_BITS-1:0] wr_data,
	input  wire logic [AW-1:0]          rd_addr,
	output logic      [SAMPLE_BITS-1:0] rd_data
);
	import swm_pkg::*;

	logic [SAMPLE_BITS-1:0] mem_q [DEPTH];
	logic [SAMPLE_BITS-1:0] rd_data_q;

	// Samples in arrival order, one write and one registered read a cycle.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

/* design/swm_med_sel.sv */
`default_nettype none

module swm_med_sel #(
	parameter int N           = swm_pkg::WINDOW_MAX_DEF,
	parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF,
	parameter int IDX_W       = 6
) (
	input  wire logic                   clk,
	input  wire logic [SAMPLE_BITS-1:0] keys [N],
	input  wire logic [IDX_W-1:0]       mid,
	output logic      [SAMPLE_BITS-1:0] sel
);
	import swm_pkg::*;

	localparam int GRP  = 8;
	localparam int LO_W = 3;
	localparam int NGRP = (N + GRP - 1) / GRP;
	localparam int HI_W = (NGRP > 1) ? $clog2(NGRP) : 1;

	logic [SAMPLE_BITS-1:0] pad [NGRP][GRP];
	logic [SAMPLE_BITS-1:0] grp_s1 [NGRP];
	logic [LO_W-1:0]        lo;
	logic [HI_W-1:0]        hi;

	assign lo = LO_W'(mid);
	assign hi = HI_W'(mid >> LO_W);

	// Row of cells folded into groups of eight, padded at the top end.
	always_comb begin
		for (int g = 0; g < NGRP; g++) begin
			for (int k = 0; k < GRP; k++) begin
				if (g * GRP + k < N) begin
					pad[g][k] = keys[g * GRP + k];
				end else begin
					pad[g][k] = '0;
				end
			end
		end
	end

	// First level: pick the entry within each group.
	always_ff @(posedge clk) begin
		for (int g = 0; g < NGRP; g++) begin
			grp_s1[g] <= pad[g][lo];
		end
	end

	// Second level: pick the group.
	assign sel = grp_s1[hi];

endmodule

`default_nettype wire

/* design/sliding_window_median.sv */
`default_nettype none

// Sliding-window median filter. Each sample beat enters a window of the last
// window_size samples (1 to WINDOW_MAX; zero counts as one, larger values
// saturate); once the window is full, every beat yields the lower median of
// the window. A beat with restart set empties the window first, and writing
// window_size empties it as well. The sorted window lives in a row of cells
// that shift as a whole: one state removes the evicted sample, the next
// inserts the new one, and the median comes out of a two-level registered
// selection. A beat takes ST_INS alone while the window fills, adds ST_MED1
// and ST_MED2 for the beat that fills it, and ST_RMV as well for every later
// beat, which always evicts a sample and yields a median. A median that finds
// the output register still occupied holds the block in ST_MED2 until the
// register frees. A result waiting in the output register does not block the
// next sample beat; only the next median waits for it. The arrival-order
// copy is a RAM that needs no clearing after reset.
module sliding_window_median #(
	parameter int WINDOW_MAX  = swm_pkg::WINDOW_MAX_DEF,
	parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_wr_en,
	input  wire logic [swm_pkg::CFG_W-1:0] cfg_wr_data,
	swm_in_if.sink                         samples,
	swm_out_if.source                      medians
);
	import swm_pkg::*;

	localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int CNT_W = $clog2(WINDOW_MAX + 1);
	localparam logic [CNT_W-1:0] WMAX_C = CNT_W'(WINDOW_MAX);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_RMV  = 5'b00010,
		ST_INS  = 5'b00100,
		ST_MED1 = 5'b01000,
		ST_MED2 = 5'b10000
	} state_t;

	state_t                 st_q;
	logic [CNT_W-1:0]       w_q;
	logic [IDX_W-1:0]       mid_q;
	logic [CNT_W-1:0]       fill_q;
	logic [IDX_W-1:0]       ptr_q;
	logic                   evict_q;
	logic                   out_valid_q;
	logic [SAMPLE_BITS-1:0] x_q;
	logic [SAMPLE_BITS-1:0] median_q;

	logic [CNT_W-1:0]       eff_size;
	logic [CNT_W-1:0]       eff_less1;
	logic [CNT_W-1:0]       fill_inc;
	logic [CNT_W-1:0]       ptr_inc;
	logic [IDX_W-1:0]       slot;
	logic                   in_fire;
	logic                   out_free;
	logic [SAMPLE_BITS-1:0] old_key;
	logic [SAMPLE_BITS-1:0] med_sel;
	cell_ctl_t              ctl;

	logic [SAMPLE_BITS-1:0] cell_key   [WINDOW_MAX];
	logic                   cell_after [WINDOW_MAX];
	logic [SAMPLE_BITS-1:0] lk         [WINDOW_MAX];
	logic [SAMPLE_BITS-1:0] rk         [WINDOW_MAX];
	logic                   la         [WINDOW_MAX];

	// Effective window size from the register value.
	always_comb begin
		if (cfg_wr_data == '0) begin
			eff_size = CNT_W'(1);
		end else if (32'(cfg_wr_data) > 32'(WINDOW_MAX)) begin
			eff_size = WMAX_C;
		end else begin
			eff_size = CNT_W'(cfg_wr_data);
		end
	end
	assign eff_less1 = eff_size - CNT_W'(1);

	assign in_fire  = samples.valid && samples.ready;
	assign out_free = !out_valid_q || medians.ready;
	assign fill_inc = fill_q + CNT_W'(1);
	assign ptr_inc  = CNT_W'(ptr_q) + CNT_W'(1);
	assign slot     = evict_q ? ptr_q : fill_q[IDX_W-1:0];

	assign ctl.rmv = (st_q == ST_RMV);
	assign ctl.ins = (st_q == ST_INS);

	// Sequencer and window bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			w_q         <= CNT_W'(1);
			mid_q       <= '0;
			fill_q      <= '0;
			ptr_q       <= '0;
			evict_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (st_q == ST_MED2 && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && medians.ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_wr_en) begin
				w_q    <= eff_size;
				mid_q  <= IDX_W'(eff_less1 >> 1);
				fill_q <= '0;
				ptr_q  <= '0;
			end
			unique case (st_q)
				ST_IDLE: begin
					if (in_fire) begin
						evict_q <= !samples.restart && (fill_q == w_q);
						if (samples.restart) begin
							fill_q <= '0;
							ptr_q  <= '0;
							st_q   <= ST_INS;
						end else if (fill_q == w_q) begin
							st_q <= ST_RMV;
						end else begin
							st_q <= ST_INS;
						end
					end
				end
				ST_RMV: begin
					fill_q <= fill_q - CNT_W'(1);
					st_q   <= ST_INS;
				end
				ST_INS: begin
					fill_q <= fill_inc;
					if (evict_q) begin
						ptr_q <= (ptr_inc == w_q) ? '0 : IDX_W'(ptr_inc);
					end
					st_q <= (fill_inc == w_q) ? ST_MED1 : ST_IDLE;
				end
				ST_MED1: begin
					st_q <= ST_MED2;
				end
				ST_MED2: begin
					if (out_free) begin
						st_q <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Sample and result payload.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			x_q <= samples.sample;
		end
		if (st_q == ST_MED2 && out_free) begin
			median_q <= med_sel;
		end
	end

	assign samples.ready  = (st_q == ST_IDLE);
	assign medians.valid  = out_valid_q;
	assign medians.median = median_q;

	// Arrival order, read at the oldest slot in every cycle.
	swm_ring #(
		.DEPTH       (WINDOW_MAX),
		.SAMPLE_BITS (SAMPLE_BITS),
		.AW          (IDX_W)
	) u_ring (
		.clk     (clk),
		.wr_en   (ctl.ins),
		.wr_addr (slot),
		.wr_data (x_q),
		.rd_addr (ptr_q),
		.rd_data (old_key)
	);

	// Sorted window: a row of cells wired to their neighbors.
	for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
		if (i == 0) begin : g_first
			assign lk[i] = x_q;
			assign la[i] = 1'b0;
		end else begin : g_mid
			assign lk[i] = cell_key[i-1];
			assign la[i] = cell_after[i-1];
		end
		if (i == WINDOW_MAX - 1) begin : g_last
			assign rk[i] = cell_key[i];
		end else begin : g_inner
			assign rk[i] = cell_key[i+1];
		end

		swm_cell #(
			.SAMPLE_BITS (SAMPLE_BITS),
			.CNT_W       (CNT_W),
			.IDX         (i)
		) u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.fill       (fill_q),
			.x          (x_q),
			.d          (old_key),
			.left_key   (lk[i]),
			.left_after (la[i]),
			.right_key  (rk[i]),
			.key        (cell_key[i]),
			.after      (cell_after[i])
		);
	end

	// Median tap of the sorted row.
	swm_med_sel #(
		.N           (WINDOW_MAX),
		.SAMPLE_BITS (SAMPLE_BITS),
		.IDX_W       (IDX_W)
	) u_med_sel (
		.clk  (clk),
		.keys (cell_key),
		.mid  (mid_q),
		.sel  (med_sel)
	);

`ifndef SYNTHESIS
	a_fill_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= w_q)
		else $error("fill count exceeds window size");

	a_ptr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		CNT_W'(ptr_q) < w_q)
		else $error("oldest pointer outside window");

	a_remove_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_RMV) |-> (fill_q == w_q))
		else $error("removal from a window that is not full");

	a_median_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_MED1) |-> (fill_q == w_q))
		else $error("median taken from a window that is not full");

	a_result_from_select: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(st_q == ST_MED2))
		else $error("result beat raised outside median select");
`endif

endmodule

`default_nettype wire

/* tb/sliding_window_median_tb.sv */
`timescale 1ns / 100ps

module sliding_window_median_tb;

	localparam int WMAX   = swm_pkg::WINDOW_MAX_DEF;
	localparam int SB     = swm_pkg::SAMPLE_BITS_DEF;
	localparam int CFG_W  = swm_pkg::CFG_W;
	// Cycles to let the block finish an item that gives no median.
	localparam int SETTLE = 8;

	typedef logic signed [SB-1:0] sample_t;

	localparam sample_t S_MIN = {1'b1, {(SB-1){1'b0}}};
	localparam sample_t S_MAX = {1'b0, {(SB-1){1'b1}}};

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [CFG_W-1:0] cfg_wr_data;

	swm_in_if #(.SAMPLE_BITS(SB)) smp_if ();
	swm_out_if #(.SAMPLE_BITS(SB)) med_if ();

	sliding_window_median #(
		.WINDOW_MAX (WMAX),
		.SAMPLE_BITS(SB)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.samples    (smp_if),
		.medians    (med_if)
	);

	// Shadow of the filter: samples in arrival order, the same samples in
	// ascending order, and the medians still owed by the block.
	sample_t history [$];
	sample_t ordered [$];
	sample_t medians_due [$];
	int      win_len;
	int      failures;
	bit      steady;
	sample_t median_want;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Hard stop in case the block hangs.
	initial begin
		#2_000_000;
		$display("Some tests failed");
		$finish;
	end

	// Apply one accepted sample to the shadow window and queue its median once full.
	function automatic void advance_window(sample_t value, logic rst);
		sample_t evicted;
		int      pos;
		if (rst) begin
			history.delete();
			ordered.delete();
		end
		if (history.size() == win_len) begin
			evicted = history.pop_front();
			pos = 0;
			while (ordered[pos] != evicted)
				pos++;
			ordered.delete(pos);
		end
		history.insert(history.size(), value);
		pos = 0;
		while (pos < ordered.size() && ordered[pos] <= value)
			pos++;
		ordered.insert(pos, value);
		if (history.size() == win_len)
			medians_due.insert(medians_due.size(), ordered[(win_len - 1) / 2]);
	endfunction

	function automatic sample_t rand_sample();
		int k;
		k = $urandom_range(9);
		case (k)
			0: return S_MIN;
			1: return S_MAX;
			2, 3: return sample_t'(int'($urandom_range(8)) - 4);
			default: return sample_t'({$urandom, $urandom});
		endcase
	endfunction

	// Present one sample beat, with a random gap first, and wait for it to be taken.
	task automatic send_sample(input sample_t value, input logic rst);
		while (!steady && $urandom_range(99) < 16) begin
			smp_if.valid <= 1'b0;
			@(posedge clk);
		end
		smp_if.valid   <= 1'b1;
		smp_if.sample  <= value;
		smp_if.restart <= rst;
		@(posedge clk);
		while (smp_if.ready !== 1'b1)
			@(posedge clk);
		advance_window(value, rst);
	endtask

	// Wait for every owed median, then let any item without a median finish.
	task automatic drain();
		smp_if.valid <= 1'b0;
		while (medians_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Writing the size empties the window in the block and in the shadow.
	task automatic write_window_size(input logic [CFG_W-1:0] value);
		drain();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		if (value == 0)
			win_len = 1;
		else if (value > WMAX)
			win_len = WMAX;
		else
			win_len = value;
		history.delete();
		ordered.delete();
	endtask

	// Size one straight out of reset; restart on the very first beat.
	task automatic test_default_size();
		send_sample(S_MIN, 1'b1);
		send_sample(S_MAX, 1'b0);
		send_sample(sample_t'(0), 1'b0);
		send_sample(sample_t'(-1), 1'b1);
	endtask

	// A size of zero behaves as a window of one sample.
	task automatic test_size_zero();
		write_window_size(CFG_W'(0));
		send_sample(sample_t'(5), 1'b0);
		send_sample(sample_t'(5), 1'b1);
	endtask

	// Odd window: extremes, a restart in mid-window and runs of equal samples.
	task automatic test_odd_window();
		write_window_size(CFG_W'(3));
		send_sample(S_MIN, 1'b0);
		send_sample(S_MAX, 1'b0);
		send_sample(sample_t'(0), 1'b0);
		send_sample(sample_t'(-1), 1'b0);
		send_sample(S_MIN, 1'b0);
		send_sample(sample_t'(7), 1'b1);
		send_sample(sample_t'(7), 1'b0);
		send_sample(sample_t'(7), 1'b0);
		send_sample(sample_t'(3), 1'b0);
		send_sample(sample_t'(7), 1'b0);
	endtask

	// Even window: the smaller of the two middle values comes out.
	task automatic test_even_window();
		write_window_size(CFG_W'(2));
		send_sample(sample_t'(10), 1'b0);
		send_sample(sample_t'(-10), 1'b0);
		send_sample(sample_t'(10), 1'b0);
		send_sample(sample_t'(10), 1'b0);
		send_sample(S_MAX, 1'b0);
	endtask

	// Random samples over a range of sizes, saturating ones among them.
	task automatic test_random_sizes();
		logic [CFG_W-1:0] plan [9];
		int               count;
		plan = '{7'd1, 7'd127, 7'd2, 7'd5, 7'd64, 7'd0, 7'd65, 7'd3, 7'd8};
		foreach (plan[i]) begin
			write_window_size(plan[i]);
			count = (win_len > 16) ? win_len + 20 : 30;
			repeat (count)
				send_sample(rand_sample(), $urandom_range(win_len * 3 + 9) == 0);
		end
	endtask

	// A long stretch with samples offered without gaps and results always taken.
	task automatic test_back_to_back();
		write_window_size(CFG_W'(7));
		steady = 1'b1;
		repeat (100)
			send_sample(rand_sample(), $urandom_range(60) == 0);
		drain();
		steady = 1'b0;
	endtask

	// The result side stalls at random unless a steady stretch is running.
	always @(posedge clk)
		med_if.ready <= steady || ($urandom_range(99) >= 16);

	// Compare each median beat with the oldest owed median.
	always @(posedge clk) begin
		if (med_if.valid === 1'b1 && med_if.ready === 1'b1) begin
			if (medians_due.size() == 0) begin
				if (failures < 10)
					$display("%0t: median %0d with none owed", $realtime, med_if.median);
				failures++;
			end else begin
				median_want = medians_due.pop_front();
				if (med_if.median !== median_want) begin
					if (failures < 10)
						$display("%0t: median expected %0d, got %0d", $realtime,
							median_want, med_if.median);
					failures++;
				end
			end
		end
	end

	initial begin
		failures       = 0;
		steady         = 1'b0;
		win_len        = 1;
		arst_n         = 1'b0;
		cfg_wr_en      <= 1'b0;
		cfg_wr_data    <= '0;
		smp_if.valid   <= 1'b0;
		smp_if.sample  <= '0;
		smp_if.restart <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_size();
		test_size_zero();
		test_odd_window();
		test_even_window();
		test_random_sizes();
		test_back_to_back();
		drain();

		if (failures == 0 && medians_due.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
